// ===== hdl/qte_pkg.sv =====
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, constants and the arctangent table for the quaternion to
// Euler angle pipeline.
// ----------------------------------------------------------------------------
package qte_pkg;

	localparam int QW     = 16;              // quaternion component width
	localparam int PW     = 2 * QW;          // product width
	localparam int OPW    = 34;              // atan2 operand width, Q.28
	localparam int SW     = 30;              // clamped pitch argument width
	localparam int RADW   = 57;              // radicand width, 2^56 fits
	localparam int ROOTW  = 29;              // square root width
	localparam int NQ     = ROOTW;           // square root stages
	localparam int CW     = 54;              // CORDIC datapath width
	localparam int ZW     = 28;              // Q.24 angle accumulator width
	localparam int NSTG   = 25;              // CORDIC iterations
	localparam int AW     = 16;              // output angle width
	localparam int PAW    = 15;              // pitch output width
	localparam int PRESHIFT = 16;            // CORDIC operand prescale

	// cordic latency: pre-rotation, iterations, rounding
	localparam int CLAT   = NSTG + 2;
	// full latency: products, sums, radicand, square root, cordic
	localparam int LAT    = 3 + NQ + CLAT;
	// extra delay on yaw and roll so they meet pitch
	localparam int YRD    = LAT - 2 - CLAT;

	localparam logic signed [OPW-1:0] ONE_Q28    = OPW'(64'sd268435456);
	localparam logic signed [ZW-1:0]  HALF_PI_Q24 = ZW'(64'sd26353589);
	localparam logic signed [AW-1:0]  YAW_LIM    = 16'sd25736;
	localparam logic signed [AW-1:0]  PITCH_LIM  = 16'sd12868;

	function automatic logic signed [ZW-1:0] atan_q24(input int idx);
		logic signed [ZW-1:0] v;
		case (idx)
			0:  v = ZW'(64'sd13176795);
			1:  v = ZW'(64'sd7778716);
			2:  v = ZW'(64'sd4110060);
			3:  v = ZW'(64'sd2086331);
			4:  v = ZW'(64'sd1047214);
			5:  v = ZW'(64'sd524117);
			6:  v = ZW'(64'sd262123);
			7:  v = ZW'(64'sd131069);
			default: v = (idx < NSTG) ? (ZW'(1) <<< (NSTG - 1 - idx)) : '0;
		endcase
		return v;
	endfunction

endpackage

// ===== hdl/qte_isqrt.sv =====
// ----------------------------------------------------------------------------
// qte_isqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qte_isqrt (
	input  logic                       clk,
	input  logic                       en,
	input  logic [qte_pkg::RADW-1:0]   rad,
	output logic [qte_pkg::ROOTW-1:0]  root
);
	import qte_pkg::*;

	localparam int RW = RADW + 1;

	logic [RADW-1:0] n_s [0:NQ-1];
	logic [RW-1:0]   r_s [0:NQ-1];

	for (genvar k = 0; k < NQ; k++) begin : g_stage
		logic [RADW-1:0] n_in;
		logic [RW-1:0]   r_in;
		logic [RW-1:0]   bitv;
		logic [RW-1:0]   sum;
		logic            take;

		if (k == 0) begin : g_first
			assign n_in = rad;
			assign r_in = '0;
		end else begin : g_next
			assign n_in = n_s[k-1];
			assign r_in = r_s[k-1];
		end

		assign bitv = RW'(1) << (RADW - 1 - 2 * k);
		assign sum  = r_in + bitv;
		assign take = {1'b0, n_in} >= sum;

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k] <= take ? (n_in - sum[RADW-1:0]) : n_in;
				r_s[k] <= take ? ((r_in >> 1) + bitv) : (r_in >> 1);
			end
		end
	end

	assign root = r_s[NQ-1][ROOTW-1:0];

endmodule

// ===== hdl/qte_cordic.sv =====
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC: atan2(y, x) rounded to Q3.13 and saturated.
// ----------------------------------------------------------------------------
module qte_cordic (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [qte_pkg::OPW-1:0]  vec_y,
	input  logic signed [qte_pkg::OPW-1:0]  vec_x,
	input  logic signed [qte_pkg::AW-1:0]   limit,
	output logic signed [qte_pkg::AW-1:0]   angle
);
	import qte_pkg::*;

	logic signed [CW-1:0] x_s [0:NSTG];
	logic signed [CW-1:0] y_s [0:NSTG];
	logic signed [ZW-1:0] z_s [0:NSTG];
	logic                 zero_s [0:NSTG];

	logic signed [CW-1:0] xw, yw;
	logic signed [ZW-1:0] zf, zr;
	logic signed [ZW-12:0] rs;
	logic signed [ZW-12:0] lim_w;

	assign xw = {{(CW-OPW-PRESHIFT){vec_x[OPW-1]}}, vec_x, PRESHIFT'(0)};
	assign yw = {{(CW-OPW-PRESHIFT){vec_y[OPW-1]}}, vec_y, PRESHIFT'(0)};

	// turn left half plane vectors by a quarter turn first
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (vec_x == '0) && (vec_y == '0);
			if (!xw[CW-1]) begin
				x_s[0] <= xw;
				y_s[0] <= yw;
				z_s[0] <= '0;
			end else if (!yw[CW-1]) begin
				x_s[0] <= yw;
				y_s[0] <= -xw;
				z_s[0] <= HALF_PI_Q24;
			end else begin
				x_s[0] <= -yw;
				y_s[0] <= xw;
				z_s[0] <= -HALF_PI_Q24;
			end
		end
	end

	for (genvar i = 0; i < NSTG; i++) begin : g_iter
		logic signed [CW-1:0] dx, dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (!y_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + atan_q24(i);
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - atan_q24(i);
				end
			end
		end
	end

	// round half up to Q3.13, then clip
	assign zf    = zero_s[NSTG] ? '0 : z_s[NSTG];
	assign zr    = zf + ZW'(1024);
	assign rs    = zr[ZW-1:11];
	assign lim_w = (ZW-11)'(limit);

	always_ff @(posedge clk) begin
		if (en) begin
			if (rs > lim_w)
				angle <= limit;
			else if (rs < -lim_w)
				angle <= -limit;
			else
				angle <= rs[AW-1:0];
		end
	end

endmodule

// ===== hdl/quaternion_to_euler_angles.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Unit quaternion (Q2.14) to ZYX Euler angles yaw, pitch, roll (Q3.13 rad).
//
//  port group   dir  beat content (lowest bit first)
//  s_axis       in   quat_w[15:0] quat_x[31:16] quat_y[47:32] quat_z[63:48]
//  m_axis       out  yaw[15:0] pitch[30:16] roll[46:31] zero pad[47]
//
//  One beat per cycle in and out unless the output stalls; the latency is set
//  by the 29 stage square root and the 27 register CORDIC on the pitch path.
//  Yaw and roll run their CORDIC early and wait in a delay line.
//  arst_n clears the valid bits and the input skid valid flag only.
//  A stall downstream freezes the whole pipeline; one input beat is still
//  taken into the skid register, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata    // yaw_angle, pitch_angle, roll_angle, pad
);
	import qte_pkg::*;

	// input skid register
	logic [63:0] skid_q;
	logic        skid_v_q;
	logic [63:0] src;
	logic        src_v;
	logic        en;

	logic [LAT:1] vld_q;

	// product stage
	logic signed [PW-1:0] p_ww_s1, p_xx_s1, p_zz_s1;
	logic signed [PW-1:0] p_wz_s1, p_xy_s1, p_wx_s1, p_yz_s1, p_wy_s1, p_xz_s1;
	logic signed [QW-1:0] qw, qx, qy, qz;

	// sum stage
	logic signed [OPW-1:0] yn_s2, yd_s2, rn_s2, rd_s2;
	logic signed [SW-1:0]  s_s2;
	logic signed [OPW-1:0] s_raw;

	// radicand stage
	logic [RADW-1:0]      n_s3;
	logic signed [SW-1:0] s_s3;
	logic signed [2*SW-1:0] sq;

	logic signed [SW-1:0]    s_dly_q [0:NQ-1];
	logic [ROOTW-1:0]        root;
	logic signed [AW-1:0]    yaw_c, roll_c, pitch_c;
	logic signed [AW-1:0]    yaw_dly_q  [0:YRD-1];
	logic signed [AW-1:0]    roll_dly_q [0:YRD-1];

	// advance everything unless a finished beat is held
	assign en            = !vld_q[LAT] || m_axis_tready;
	assign s_axis_tready = !skid_v_q;
	assign src           = skid_v_q ? skid_q : s_axis_tdata;
	assign src_v         = skid_v_q || s_axis_tvalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (en) begin
			skid_v_q <= 1'b0;
		end else if (s_axis_tvalid) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q)
			skid_q <= s_axis_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-1:1], src_v};
		end
	end

	assign qw = src[15:0];
	assign qx = src[31:16];
	assign qy = src[47:32];
	assign qz = src[63:48];

	always_ff @(posedge clk) begin
		if (en) begin
			p_ww_s1 <= qw * qw;
			p_xx_s1 <= qx * qx;
			p_zz_s1 <= qz * qz;
			p_wz_s1 <= qw * qz;
			p_xy_s1 <= qx * qy;
			p_wx_s1 <= qw * qx;
			p_yz_s1 <= qy * qz;
			p_wy_s1 <= qw * qy;
			p_xz_s1 <= qx * qz;
		end
	end

	// atan2 operands and the clamped arcsine argument, all Q.28
	assign s_raw = (OPW'(p_wy_s1) - OPW'(p_xz_s1)) <<< 1;

	always_ff @(posedge clk) begin
		if (en) begin
			yn_s2 <= (OPW'(p_wz_s1) + OPW'(p_xy_s1)) <<< 1;
			yd_s2 <= ((OPW'(p_ww_s1) + OPW'(p_xx_s1)) <<< 1) - ONE_Q28;
			rn_s2 <= (OPW'(p_wx_s1) + OPW'(p_yz_s1)) <<< 1;
			rd_s2 <= ((OPW'(p_ww_s1) + OPW'(p_zz_s1)) <<< 1) - ONE_Q28;
			if (s_raw > ONE_Q28)
				s_s2 <= SW'(ONE_Q28);
			else if (s_raw < -ONE_Q28)
				s_s2 <= SW'(-ONE_Q28);
			else
				s_s2 <= s_raw[SW-1:0];
		end
	end

	// radicand 1 - s^2 in Q.56
	assign sq = s_s2 * s_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s3 <= (RADW'(1) << (RADW - 1)) - sq[RADW-1:0];
			s_s3 <= s_s2;
		end
	end

	// hold s beside the square root
	always_ff @(posedge clk) begin
		if (en) begin
			s_dly_q[0] <= s_s3;
			for (int i = 1; i < NQ; i++)
				s_dly_q[i] <= s_dly_q[i-1];
		end
	end

	qte_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (n_s3),
		.root (root)
	);

	qte_cordic u_yaw (
		.clk   (clk),
		.en    (en),
		.vec_y (yn_s2),
		.vec_x (yd_s2),
		.limit (YAW_LIM),
		.angle (yaw_c)
	);

	qte_cordic u_roll (
		.clk   (clk),
		.en    (en),
		.vec_y (rn_s2),
		.vec_x (rd_s2),
		.limit (YAW_LIM),
		.angle (roll_c)
	);

	// arcsine as atan2(s, sqrt(1 - s^2))
	qte_cordic u_pitch (
		.clk   (clk),
		.en    (en),
		.vec_y (OPW'(s_dly_q[NQ-1])),
		.vec_x ($signed(OPW'(root))),
		.limit (PITCH_LIM),
		.angle (pitch_c)
	);

	// delay yaw and roll until pitch is done
	always_ff @(posedge clk) begin
		if (en) begin
			yaw_dly_q[0]  <= yaw_c;
			roll_dly_q[0] <= roll_c;
			for (int i = 1; i < YRD; i++) begin
				yaw_dly_q[i]  <= yaw_dly_q[i-1];
				roll_dly_q[i] <= roll_dly_q[i-1];
			end
		end
	end

	assign m_axis_tvalid = vld_q[LAT];
	assign m_axis_tdata  = {1'b0, roll_dly_q[YRD-1], pitch_c[PAW-1:0], yaw_dly_q[YRD-1]};

endmodule
